@@ design/blk3_pkg.sv @@
// shared types, constants and tables of the blake3 block compressor
package blk3_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;
    typedef word_t [7:0]  cv_t;
    typedef logic [3:0]   idx_t;

    // one block as handed to the round core
    typedef struct packed {
        cv_t         cv;
        state_t      msg;
        logic [63:0] counter;
        logic [6:0]  len;
        logic [4:0]  flags;
    } blk3_job_t;

    // status of the round core
    typedef struct packed {
        logic idle;
        logic done;
    } blk3_core_status_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_RUN,
        CORE_DONE
    } blk3_core_state_t;

    localparam int LANE_COUNT = 4;

    localparam cv_t BLK3_IV = '{
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    // message word permutation applied after each full round
    localparam idx_t BLK3_PERM [16] = '{
        4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
        4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
    };

    // state word indexes a, b, c, d of each lane, column and diagonal layers
    localparam idx_t BLK3_COL_IDX [4][4] = '{
        '{4'd0, 4'd4, 4'd8,  4'd12},
        '{4'd1, 4'd5, 4'd9,  4'd13},
        '{4'd2, 4'd6, 4'd10, 4'd14},
        '{4'd3, 4'd7, 4'd11, 4'd15}
    };

    localparam idx_t BLK3_DIA_IDX [4][4] = '{
        '{4'd0, 4'd5, 4'd10, 4'd15},
        '{4'd1, 4'd6, 4'd11, 4'd12},
        '{4'd2, 4'd7, 4'd8,  4'd13},
        '{4'd3, 4'd4, 4'd9,  4'd14}
    };

endpackage

@@ design/blk3_g_lane.sv @@
// one g mixing lane: quarter-round on four state words with two message words
module blk3_g_lane
    import blk3_pkg::*;
(
    input  word_t a_i,
    input  word_t b_i,
    input  word_t c_i,
    input  word_t d_i,
    input  word_t x_i,
    input  word_t y_i,
    output word_t a_o,
    output word_t b_o,
    output word_t c_o,
    output word_t d_o
);

    word_t a1, b1, c1, d1, a2, d2, c2, t_d1, t_b1, t_d2, t_b2;

    // first half
    assign a1   = a_i + b_i + x_i;
    assign t_d1 = d_i ^ a1;
    assign d1   = {t_d1[15:0], t_d1[31:16]};
    assign c1   = c_i + d1;
    assign t_b1 = b_i ^ c1;
    assign b1   = {t_b1[11:0], t_b1[31:12]};

    // second half
    assign a2   = a1 + b1 + y_i;
    assign t_d2 = d1 ^ a2;
    assign d2   = {t_d2[7:0], t_d2[31:8]};
    assign c2   = c1 + d2;
    assign t_b2 = b1 ^ c2;

    assign a_o = a2;
    assign b_o = {t_b2[6:0], t_b2[31:7]};
    assign c_o = c2;
    assign d_o = d2;

endmodule

@@ design/blk3_core.sv @@
// round core: four g lanes on a registered state, one column or diagonal layer a cycle
module blk3_core
    import blk3_pkg::*;
#(
    parameter int ROUND_COUNT = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start_i,
    input  blk3_job_t         job_i,
    input  logic              res_take_i,
    output blk3_core_status_t status_o,
    output state_t            v_o,
    output cv_t               cv_o
);

    localparam int LAYER_COUNT = 2 * ROUND_COUNT;
    localparam int CW          = $clog2(LAYER_COUNT);

    blk3_core_state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    state_t           v_reg, v_next;
    state_t           m_reg, m_next;
    cv_t              cv_reg, cv_next;
    logic             is_diag;
    logic             last_layer;

    word_t lane_a [LANE_COUNT];
    word_t lane_b [LANE_COUNT];
    word_t lane_c [LANE_COUNT];
    word_t lane_d [LANE_COUNT];

    assign is_diag    = cnt_reg[0];
    assign last_layer = (cnt_reg == CW'(LAYER_COUNT - 1));

    // lanes with their operand selection
    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        idx_t  ia, ib, ic, id;
        word_t x, y;

        assign ia = is_diag ? BLK3_DIA_IDX[g][0] : BLK3_COL_IDX[g][0];
        assign ib = is_diag ? BLK3_DIA_IDX[g][1] : BLK3_COL_IDX[g][1];
        assign ic = is_diag ? BLK3_DIA_IDX[g][2] : BLK3_COL_IDX[g][2];
        assign id = is_diag ? BLK3_DIA_IDX[g][3] : BLK3_COL_IDX[g][3];
        assign x  = is_diag ? m_reg[8 + 2 * g] : m_reg[2 * g];
        assign y  = is_diag ? m_reg[9 + 2 * g] : m_reg[2 * g + 1];

        blk3_g_lane u_lane (
            .a_i (v_reg[ia]),
            .b_i (v_reg[ib]),
            .c_i (v_reg[ic]),
            .d_i (v_reg[id]),
            .x_i (x),
            .y_i (y),
            .a_o (lane_a[g]),
            .b_o (lane_b[g]),
            .c_o (lane_c[g]),
            .d_o (lane_d[g])
        );
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CORE_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        v_reg  <= v_next;
        m_reg  <= m_next;
        cv_reg <= cv_next;
    end

    // next state, layer writeback and message permutation
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        v_next     = v_reg;
        m_next     = m_reg;
        cv_next    = cv_reg;
        unique case (state_reg)
            CORE_IDLE: begin
                if (start_i) begin
                    for (int i = 0; i < 8; i++) begin
                        v_next[i] = job_i.cv[i];
                    end
                    for (int i = 0; i < 4; i++) begin
                        v_next[8 + i] = BLK3_IV[i];
                    end
                    v_next[12] = job_i.counter[31:0];
                    v_next[13] = job_i.counter[63:32];
                    v_next[14] = {25'd0, job_i.len};
                    v_next[15] = {27'd0, job_i.flags};
                    m_next     = job_i.msg;
                    cv_next    = job_i.cv;
                    cnt_next   = '0;
                    state_next = CORE_RUN;
                end
            end
            CORE_RUN: begin
                for (int i = 0; i < LANE_COUNT; i++) begin
                    if (is_diag) begin
                        v_next[BLK3_DIA_IDX[i][0]] = lane_a[i];
                        v_next[BLK3_DIA_IDX[i][1]] = lane_b[i];
                        v_next[BLK3_DIA_IDX[i][2]] = lane_c[i];
                        v_next[BLK3_DIA_IDX[i][3]] = lane_d[i];
                    end else begin
                        v_next[BLK3_COL_IDX[i][0]] = lane_a[i];
                        v_next[BLK3_COL_IDX[i][1]] = lane_b[i];
                        v_next[BLK3_COL_IDX[i][2]] = lane_c[i];
                        v_next[BLK3_COL_IDX[i][3]] = lane_d[i];
                    end
                end
                if (is_diag) begin
                    for (int j = 0; j < 16; j++) begin
                        m_next[j] = m_reg[BLK3_PERM[j]];
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (last_layer) begin
                    state_next = CORE_DONE;
                end
            end
            CORE_DONE: begin
                if (res_take_i) begin
                    state_next = CORE_IDLE;
                end
            end
            default: begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    assign status_o.idle = (state_reg == CORE_IDLE);
    assign status_o.done = (state_reg == CORE_DONE);
    assign v_o           = v_reg;
    assign cv_o          = cv_reg;

    // a start from idle enters the first column layer
    a_start_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CORE_IDLE && start_i) |=> (state_reg == CORE_RUN && cnt_reg == '0))
        else $error("core did not begin at the first layer");

    // the last layer always ends in done
    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CORE_RUN && last_layer) |=> (state_reg == CORE_DONE))
        else $error("core did not finish after the last layer");

    // a finished result holds until it is taken
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CORE_DONE && !res_take_i) |=>
            (state_reg == CORE_DONE && $stable(v_reg) && $stable(cv_reg)))
        else $error("finished result changed before it was taken");

endmodule

@@ design/blk3_merge.sv @@
// merging stage: feed-forward xor of the final lane state and the chaining value
module blk3_merge
    import blk3_pkg::*;
(
    input  state_t v_i,
    input  cv_t    cv_i,
    output state_t out_o
);

    // low half folds in the high half, high half folds in the input chaining value
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            out_o[i]     = v_i[i] ^ v_i[i + 8];
            out_o[i + 8] = v_i[i + 8] ^ cv_i[i];
        end
    end

endmodule

@@ design/blake3_block_compressor.sv @@
// top level of the blake3 block compressor: stream channels, key registers, chaining value
//
//  channel  | direction | transaction
//  ---------+-----------+--------------------------------------------------------------
//  s_       | in        | one 64-byte message block with counter, length, flags, restart
//  m_       | out       | sixteen output words of one compression
//  apb      | in        | write or read of key_word_0 .. key_word_7 at byte address 4*i
//
//  a block is loaded into the round core, runs one column or diagonal layer of the
//  four-lane round core per cycle, and is merged into the output register. the
//  chaining value of a block is the result of the block before it, or the key
//  registers when restart is set, so blocks go through the round core one at a time;
//  a one-entry input buffer takes the next block while the current one runs, and the
//  output register holds a finished result. an output stall holds the core in done;
//  reset is synchronous and sets the key registers and the stored chaining value to the iv.
module blake3_block_compressor
    import blk3_pkg::*;
#(
    parameter int ROUND_COUNT = 7
) (
    input  logic         aclk,
    input  logic         aresetn,
    // msg_words_0_1 .. msg_words_14_15 [511:0], block_counter [575:512],
    // block_length [582:576], zero [583]
    input  logic [583:0] s_tdata,
    // domain_flags [4:0], restart [5]
    input  logic [5:0]   s_tuser,
    input  logic         s_tvalid,
    output logic         s_tready,
    // out_words_0_1 .. out_words_14_15 [511:0]
    output logic [511:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    cv_t               key_reg, key_next;
    cv_t               cv_reg, cv_next;
    logic              in_valid_reg, in_valid_next;
    logic [583:0]      in_data_reg, in_data_next;
    logic [5:0]        in_user_reg, in_user_next;
    logic              out_valid_reg, out_valid_next;
    state_t            out_data_reg, out_data_next;
    logic              start;
    logic              take;
    blk3_job_t         job;
    blk3_core_status_t status;
    state_t            core_v;
    cv_t               core_cv;
    state_t            merged;

    // configuration port
    assign pready = 1'b1;
    assign prdata = key_reg[paddr[4:2]];

    always_comb begin
        key_next = key_reg;
        if (psel && penable && pwrite && pready) begin
            key_next[paddr[4:2]] = pwdata;
        end
    end

    // input buffer and handshakes
    assign s_tready = !in_valid_reg;
    assign start    = in_valid_reg && status.idle;
    assign take     = status.done && (!out_valid_reg || m_tready);

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        in_user_next  = in_user_reg;
        if (start) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_data_next  = s_tdata;
            in_user_next  = s_tuser;
        end
    end

    // job assembly, chaining value chosen at start
    always_comb begin
        job.cv      = in_user_reg[5] ? key_reg : cv_reg;
        job.msg     = in_data_reg[511:0];
        job.counter = in_data_reg[575:512];
        job.len     = in_data_reg[582:576];
        job.flags   = in_user_reg[4:0];
    end

    blk3_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (start),
        .job_i      (job),
        .res_take_i (take),
        .status_o   (status),
        .v_o        (core_v),
        .cv_o       (core_cv)
    );

    blk3_merge u_merge (
        .v_i   (core_v),
        .cv_i  (core_cv),
        .out_o (merged)
    );

    // output register and chaining value update
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cv_next        = cv_reg;
        if (take) begin
            out_valid_next = 1'b1;
            out_data_next  = merged;
            for (int i = 0; i < 8; i++) begin
                cv_next[i] = merged[i];
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg       <= BLK3_IV;
            cv_reg        <= BLK3_IV;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            key_reg       <= key_next;
            cv_reg        <= cv_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg  <= in_data_next;
        in_user_reg  <= in_user_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
